FILE: sv/fq_pkg.sv
// Package for the FIFO queue with search: depth, widths, operation and status codes,
// and the command struct shared by the cell chain and the top level.
// No dependencies.
`default_nettype none

package fq_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 6;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_DUMP_FWD = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP_REV = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic shift_fwd;
        logic shift_back;
        logic load;
    } t_chain_cmd;

    typedef struct packed {
        logic shift_fwd;
        logic shift_back;
        logic load;
        logic in_use;
        logic is_tail;
        logic is_head;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/fq_cell.sv
// One storage cell of the queue chain, holding a single entry.
// Depends on fq_pkg.
`default_nettype none

module fq_cell
    import fq_pkg::*;
(
    input  wire               i_clk,
    input  wire  t_cell_ctl   i_ctl,
    input  wire  [DATA_W-1:0] i_push_value,
    input  wire  [DATA_W-1:0] i_next,
    input  wire  [DATA_W-1:0] i_prev,
    input  wire  [DATA_W-1:0] i_front,
    input  wire  [DATA_W-1:0] i_rear,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_push_value;
        end else if (i_ctl.in_use && i_ctl.shift_fwd) begin
            r_data <= i_ctl.is_tail ? i_front : i_next;
        end else if (i_ctl.in_use && i_ctl.shift_back) begin
            r_data <= i_ctl.is_head ? i_rear : i_prev;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: sv/fq_chain.sv
// Row of queue cells with the front entry in cell zero; rotates the occupied cells
// in either direction and loads a pushed value behind the last entry.
// Depends on fq_pkg and fq_cell.
`default_nettype none

module fq_chain
    import fq_pkg::*;
(
    input  wire               i_clk,
    input  wire  t_chain_cmd  i_cmd,
    input  wire  [CNT_W-1:0]  i_count,
    input  wire  [DATA_W-1:0] i_push_value,
    output logic [DATA_W-1:0] o_front,
    output logic [DATA_W-1:0] o_rear
);

    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]  w_tail;
    logic [DATA_W-1:0] w_rear;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        always_comb begin
            w_ctl.shift_fwd  = i_cmd.shift_fwd;
            w_ctl.shift_back = i_cmd.shift_back;
            w_ctl.load       = i_cmd.load && (CNT_W'(g) == i_count);
            w_ctl.in_use     = CNT_W'(g) < i_count;
            w_ctl.is_tail    = CNT_W'(g + 1) == i_count;
            w_ctl.is_head    = (g == 0);
        end

        assign w_tail[g] = w_ctl.is_tail;

        fq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_push_value (i_push_value),
            .i_next       (w_data[(g + 1) % DEPTH]),
            .i_prev       (w_data[(g + DEPTH - 1) % DEPTH]),
            .i_front      (w_data[0]),
            .i_rear       (w_rear),
            .o_data       (w_data[g])
        );
    end

    always_comb begin
        w_rear = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear = w_rear | (w_data[k] & {DATA_W{w_tail[k]}});
        end
    end

    assign o_front = w_data[0];
    assign o_rear  = w_rear;

endmodule

`default_nettype wire

FILE: sv/fifo_queue_with_search_unit.sv
// Push and pop give their result in the cycle after the transfer, one item a cycle while the output is not stalled.
// A dump walks the queue one entry a cycle, with one result for each entry.
// A search walks the same way and then adds a closing result with the match count.
// The input is stalled for the whole walk, which rotates the cell chain once around.
// Output stall holds the walk in place. Reset clears count and control only;
// the entry cells are not reset.
`default_nettype none

module fifo_queue_with_search_unit
    import fq_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire  [OP_W-1:0]   i_operation,
    input  wire  [DATA_W-1:0] i_item_value,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_out_value,
    output logic [POS_W-1:0]  o_position,
    output logic [POS_W-1:0]  o_match_count,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_CLOSE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]  r_matches, n_matches;
    logic [OP_W-1:0]   r_op, n_op;
    logic [DATA_W-1:0] r_key, n_key;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_value, n_value;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_mcount, n_mcount;
    logic              r_last, n_last;

    logic              w_out_free;
    logic              w_accept;
    logic              w_last_step;
    t_chain_cmd        w_cmd;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_rear;

    fq_chain u_chain (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_count      (r_count),
        .i_push_value (i_item_value),
        .o_front      (w_front),
        .o_rear       (w_rear)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_last_step = (r_step + CNT_W'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_matches   = r_matches;
        n_op        = r_op;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value     = r_value;
        n_pos       = r_pos;
        n_mcount    = r_mcount;
        n_last      = r_last;
        w_cmd       = '0;

        if (w_out_free) begin
            n_out_valid = 1'b0;
            n_status    = ST_OK;
            n_value     = '0;
            n_pos       = '0;
            n_mcount    = '0;
            n_last      = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_PUSH) begin
                        n_out_valid = 1'b1;
                        n_last      = 1'b1;
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd.load = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end else if (i_operation == OP_POP || i_operation == OP_DUMP_FWD ||
                                 i_operation == OP_DUMP_REV || i_operation == OP_SEARCH) begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_EMPTY;
                            n_last      = 1'b1;
                        end else if (i_operation == OP_POP) begin
                            n_out_valid     = 1'b1;
                            n_value         = w_front;
                            n_last          = 1'b1;
                            w_cmd.shift_fwd = 1'b1;
                            n_count         = r_count - CNT_W'(1);
                        end else begin
                            n_state   = S_WALK;
                            n_op      = i_operation;
                            n_key     = i_item_value;
                            n_step    = '0;
                            n_matches = '0;
                        end
                    end
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    n_step = r_step + CNT_W'(1);
                    if (r_op == OP_DUMP_REV) begin
                        w_cmd.shift_back = 1'b1;
                        n_out_valid      = 1'b1;
                        n_value          = w_rear;
                        n_pos            = POS_W'(r_count - r_step);
                        n_last           = w_last_step;
                    end else begin
                        w_cmd.shift_fwd = 1'b1;
                        if (r_op == OP_DUMP_FWD) begin
                            n_out_valid = 1'b1;
                            n_value     = w_front;
                            n_pos       = POS_W'(r_step + CNT_W'(1));
                            n_last      = w_last_step;
                        end else if (w_front == r_key) begin
                            n_out_valid = 1'b1;
                            n_pos       = POS_W'(r_step + CNT_W'(1));
                            n_matches   = r_matches + CNT_W'(1);
                        end
                    end
                    if (w_last_step) begin
                        n_state = (r_op == OP_SEARCH) ? S_CLOSE : S_IDLE;
                    end
                end
            end
            S_CLOSE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = (r_matches == '0) ? ST_NONE : ST_OK;
                    n_mcount    = POS_W'(r_matches);
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_matches   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_matches   <= n_matches;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_mcount <= n_mcount;
        r_last   <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_value   = r_value;
    assign o_position    = r_pos;
    assign o_match_count = r_mcount;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step < r_count))
        else $error("Walk step runs past the stored entries.");

    a_close_is_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |-> (r_op == OP_SEARCH))
        else $error("Closing result pending for an operation other than search.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_PUSH && r_count != CNT_W'(DEPTH))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Accepted push did not grow the queue.");

    a_walk_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> $stable(r_count))
        else $error("Entry count changed during a walk.");

endmodule

`default_nettype wire
